/* src/fixed_key_record_sorter_unit_assert.svh */
// assertion macros for the fixed key record sorter
// used by the top level; no other dependencies
`ifndef FIXED_KEY_RECORD_SORTER_UNIT_ASSERT_SVH
`define FIXED_KEY_RECORD_SORTER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FKSU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fksu check failed");

// antecedent implies consequent in the next cycle
`define FKSU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fksu check failed");

`endif

/* src/fksu_pkg.sv */
// shared types, constants and key ordering function for the record sorter
// no dependencies
`default_nettype none

package fksu_pkg;

    localparam int CAPACITY_DEF  = 2048;
    localparam int KEY_BYTES_DEF = 32;
    localparam int KEY_MAX_BYTES = 32;
    localparam int WORD_W        = 64;
    localparam int TAG_W         = 11;
    localparam int POS_W         = 11;
    localparam int KEY_W         = KEY_MAX_BYTES * 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic [TAG_W-1:0]  tag;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SORT_PRIME,
        S_SORT_LOAD,
        S_SORT_FETCH,
        S_SORT_CMP,
        S_SORT_END
    } state_t;

    // key as the ordering sees it: zero from the first zero byte on
    function automatic key_t norm_key(input rec_t r, input int unsigned nbytes);
        key_t       src;
        key_t       res;
        logic       ended;
        logic [7:0] byte_v;
        src   = {r.w0, r.w1, r.w2, r.w3};
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < KEY_MAX_BYTES; b++) begin
            byte_v = src[KEY_W-1-8*b -: 8];
            if (b >= int'(nbytes) || byte_v == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                res[KEY_W-1-8*b -: 8] = byte_v;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/fksu_rec_mem.sv */
// record store: one write port, one read port, registered read data
// depends on fksu_pkg
`default_nettype none

module fksu_rec_mem
    import fksu_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  rec_t                          wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output rec_t                          rdata
);

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/fixed_key_record_sorter_unit.sv */
// Record sorter. Loads (op 0) write each record behind the stored ones while idle;
// a load into a full store writes nothing. A load with last set sorts all stored records by
// key, ascending and stable, bytes after the first zero byte ignored. A read (op 1) returns
// the record at a sorted position, found 0 past the count; its word is read from the store,
// then registered at the output once the output is free, and no new item is taken before
// that. The sort is a bubble sort through the single-read, single-write record store: each
// compare is a fetch step (read latency), then a compare and write back; up to n-1 passes
// run, ending early after a pass without an exchange; no word is accepted during the sort.
// depends on fksu_pkg, fksu_rec_mem and fixed_key_record_sorter_unit_assert.svh
`default_nettype none

`include "fixed_key_record_sorter_unit_assert.svh"

module fixed_key_record_sorter_unit
    import fksu_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_op,
    input  wire logic [WORD_W-1:0] s_key_word0,
    input  wire logic [WORD_W-1:0] s_key_word1,
    input  wire logic [WORD_W-1:0] s_key_word2,
    input  wire logic [WORD_W-1:0] s_key_word3,
    input  wire logic [TAG_W-1:0]  s_record_tag,
    input  wire logic [POS_W-1:0]  s_read_position,
    input  wire logic              s_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [WORD_W-1:0]      m_sorted_key_word0,
    output logic [WORD_W-1:0]      m_sorted_key_word1,
    output logic [WORD_W-1:0]      m_sorted_key_word2,
    output logic [WORD_W-1:0]      m_sorted_key_word3,
    output logic [TAG_W-1:0]       m_sorted_tag,
    output logic                   m_found
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           miss_reg, miss_next;
    logic [AW-1:0]  j_reg, j_next;
    logic [AW-1:0]  limit_reg, limit_next;
    logic           swapped_reg, swapped_next;
    rec_t           carry_reg, carry_next;
    key_t           carry_norm_reg, carry_norm_next;
    rec_t           b_reg, b_next;
    key_t           b_norm_reg, b_norm_next;
    logic           m_valid_reg, m_valid_next;
    rec_t           out_reg, out_next;
    logic           found_reg, found_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    rec_t           mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    rec_t           mem_rdata;

    logic           s_fire;
    logic           full;
    logic           hit;
    logic           out_free;
    logic [CW-1:0]  count_after;
    rec_t           in_rec;

    fksu_rec_mem #(
        .DEPTH(CAPACITY)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign full        = (count_reg >= CW'(CAPACITY));
    assign hit         = (32'(s_read_position) < 32'(count_reg));
    assign out_free    = !m_valid_reg || m_ready;
    assign count_after = full ? count_reg : count_reg + CW'(1);
    assign in_rec      = '{w0: s_key_word0, w1: s_key_word1, w2: s_key_word2,
                           w3: s_key_word3, tag: s_record_tag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        miss_reg       <= miss_next;
        j_reg          <= j_next;
        limit_reg      <= limit_next;
        swapped_reg    <= swapped_next;
        carry_reg      <= carry_next;
        carry_norm_reg <= carry_norm_next;
        b_reg          <= b_next;
        b_norm_reg     <= b_norm_next;
        out_reg        <= out_next;
        found_reg      <= found_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        miss_next       = miss_reg;
        j_next          = j_reg;
        limit_next      = limit_reg;
        swapped_next    = swapped_reg;
        carry_next      = carry_reg;
        carry_norm_next = carry_norm_reg;
        b_next          = b_reg;
        b_norm_next     = b_norm_reg;
        out_next        = out_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = carry_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_op == OP_LOAD) begin
                        if (!full) begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = in_rec;
                            count_next = count_after;
                        end
                        if (s_last && count_after >= CW'(2)) begin
                            limit_next = AW'(count_after - CW'(1));
                            state_next = S_SORT_PRIME;
                        end
                    end else begin
                        mem_re     = hit;
                        mem_raddr  = AW'(s_read_position);
                        miss_next  = !hit;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (out_free) begin
                    out_next     = miss_reg ? '0 : mem_rdata;
                    found_next   = !miss_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SORT_PRIME: begin
                mem_re       = 1'b1;
                mem_raddr    = '0;
                swapped_next = 1'b0;
                state_next   = S_SORT_LOAD;
            end
            S_SORT_LOAD: begin
                carry_next      = mem_rdata;
                carry_norm_next = norm_key(mem_rdata, KEY_BYTES);
                mem_re          = 1'b1;
                mem_raddr       = AW'(1);
                j_next          = AW'(1);
                state_next      = S_SORT_FETCH;
            end
            S_SORT_FETCH: begin
                b_next      = mem_rdata;
                b_norm_next = norm_key(mem_rdata, KEY_BYTES);
                state_next  = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg - AW'(1);
                if (carry_norm_reg > b_norm_reg) begin
                    mem_wdata    = b_reg;
                    swapped_next = 1'b1;
                end else begin
                    mem_wdata       = carry_reg;
                    carry_next      = b_reg;
                    carry_norm_next = b_norm_reg;
                end
                if (j_reg == limit_reg) begin
                    state_next = S_SORT_END;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_reg + AW'(1);
                    j_next     = j_reg + AW'(1);
                    state_next = S_SORT_FETCH;
                end
            end
            S_SORT_END: begin
                mem_we    = 1'b1;
                mem_waddr = limit_reg;
                mem_wdata = carry_reg;
                if (swapped_reg && limit_reg > AW'(1)) begin
                    limit_next = limit_reg - AW'(1);
                    state_next = S_SORT_PRIME;
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign m_sorted_key_word0 = out_reg.w0;
    assign m_sorted_key_word1 = out_reg.w1;
    assign m_sorted_key_word2 = out_reg.w2;
    assign m_sorted_key_word3 = out_reg.w3;
    assign m_sorted_tag       = out_reg.tag;
    assign m_found            = found_reg;

    `FKSU_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, 32'(count_reg) <= 32'(CAPACITY))
    `FKSU_ASSERT_IMPL(a_sort_write_in_range, aclk, aresetn, mem_we && state_reg != S_IDLE, 32'(mem_waddr) < 32'(count_reg))
    `FKSU_ASSERT_IMPL(a_no_write_on_read, aclk, aresetn, state_reg == S_RD, !mem_we && !mem_re)
    `FKSU_ASSERT_NEXT(a_read_delivers, aclk, aresetn, state_reg == S_RD && out_free, m_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire
